// File: src/modbus_fc04_master_checker_assert.svh
// Assertion macros for the Modbus function 04 master.
// Each takes a label, clock, active-low reset, antecedent and consequent.
`ifndef MODBUS_FC04_MASTER_CHECKER_ASSERT_SVH
`define MODBUS_FC04_MASTER_CHECKER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MBFC4_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Consequent holds in the cycle after the antecedent.
`define MBFC4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// File: src/mbfc4_pkg.sv
// ----------------------------------------------------------------------------
// mbfc4_pkg
// Shared codes, types and the CRC-16 byte step for the function 04 master.
// ----------------------------------------------------------------------------
package mbfc4_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result item kinds
    localparam logic [1:0] OUT_REQ    = 2'd0;
    localparam logic [1:0] OUT_WORD   = 2'd1;
    localparam logic [1:0] OUT_STATUS = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_ADDRESS   = 3'd2;
    localparam logic [2:0] ST_EXCEPTION = 3'd3;
    localparam logic [2:0] ST_FUNCTION  = 3'd4;
    localparam logic [2:0] ST_SIZE      = 3'd5;
    localparam logic [2:0] ST_CRC       = 3'd6;
    localparam logic [2:0] ST_REJECTED  = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] CFG_MAX_COUNT     = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  RST_SLAVE_ADDRESS = 8'd1;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd300;
    localparam logic [6:0]  RST_MAX_COUNT     = 7'd80;

    localparam logic [7:0]  FUNC_CODE   = 8'h04;
    localparam logic [7:0]  FUNC_EXCEPT = 8'h84;
    localparam logic [6:0]  HARD_LIMIT  = 7'd124;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [3:0]  REQ_LEN     = 4'd8;
    localparam logic [7:0]  MIN_REPLY   = 8'd5;

    // Result burst handed from the core to the output stage
    typedef struct packed {
        logic        req_go;
        logic        word_go;
        logic        stat_go;
        logic [7:0]  slave;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [15:0] word;
        logic [6:0]  widx;
        logic [2:0]  status;
        logic [7:0]  exc;
        logic [31:0] total;
    } t_burst;

    // One byte through CRC-16, reflected polynomial
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/mbfc4_core.sv
// ----------------------------------------------------------------------------
// mbfc4_core
// Configuration, reply tracking state and reply judgement, one item a cycle while i_go is high.
// ----------------------------------------------------------------------------
module mbfc4_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_go,
    input  logic [1:0]            i_kind,
    input  logic [15:0]           i_start_address,
    input  logic [15:0]           i_register_count,
    input  logic [7:0]            i_rx_byte,
    output mbfc4_pkg::t_burst     o_burst
);

    logic [7:0]  r_slave,     n_slave;
    logic [15:0] r_timeout,   n_timeout;
    logic [6:0]  r_max,       n_max;
    logic        r_receiving, n_receiving;
    logic [6:0]  r_exp,       n_exp;
    logic [7:0]  r_bytes,     n_bytes;
    logic [15:0] r_elapsed,   n_elapsed;
    logic [15:0] r_crc,       n_crc;
    logic [15:0] r_lag,       n_lag;
    logic [7:0]  r_raddr,     n_raddr;
    logic [7:0]  r_rfunc,     n_rfunc;
    logic [7:0]  r_rbc,       n_rbc;
    logic [7:0]  r_pend,      n_pend;
    logic [31:0] r_fail,      n_fail;

    logic [6:0]  lim;
    logic        reject;
    logic [8:0]  data_end;
    logic [7:0]  pm4;
    logic        fin;
    logic [2:0]  st;
    logic [7:0]  exc;
    logic [15:0] got;

    always_comb begin
        n_slave     = r_slave;
        n_timeout   = r_timeout;
        n_max       = r_max;
        n_receiving = r_receiving;
        n_exp       = r_exp;
        n_bytes     = r_bytes;
        n_elapsed   = r_elapsed;
        n_crc       = r_crc;
        n_lag       = r_lag;
        n_raddr     = r_raddr;
        n_rfunc     = r_rfunc;
        n_rbc       = r_rbc;
        n_pend      = r_pend;
        n_fail      = r_fail;
        o_burst       = '0;
        o_burst.slave = r_slave;
        o_burst.addr  = i_start_address;
        o_burst.cnt   = i_register_count;
        fin      = 1'b0;
        st       = mbfc4_pkg::ST_OK;
        exc      = 8'h00;
        got      = {r_lag[7:0], r_lag[15:8]};
        lim      = (r_max > mbfc4_pkg::HARD_LIMIT) ? mbfc4_pkg::HARD_LIMIT : r_max;
        reject   = (i_register_count == 16'd0) || i_register_count[0] ||
                   (i_register_count > {9'd0, lim});
        data_end = 9'd3 + {1'b0, r_exp, 1'b0};
        pm4      = r_bytes - 8'd4;

        if (i_cfg_we) begin
            case (i_cfg_index)
                mbfc4_pkg::CFG_SLAVE_ADDRESS: n_slave   = i_cfg_data[7:0];
                mbfc4_pkg::CFG_TIMEOUT_TICKS: n_timeout = i_cfg_data;
                mbfc4_pkg::CFG_MAX_COUNT:     n_max     = i_cfg_data[6:0];
                default: ;
            endcase
        end

        if (i_go) begin
            case (i_kind)
                mbfc4_pkg::KIND_START: begin
                    if (reject) begin
                        o_burst.stat_go = 1'b1;
                        o_burst.status  = mbfc4_pkg::ST_REJECTED;
                        o_burst.total   = r_fail;
                    end else begin
                        o_burst.req_go = 1'b1;
                        n_receiving = 1'b1;
                        n_exp       = i_register_count[6:0];
                        n_bytes     = 8'd0;
                        n_elapsed   = 16'd0;
                        n_crc       = mbfc4_pkg::CRC_INIT;
                        n_lag       = 16'd0;
                        n_raddr     = 8'd0;
                        n_rfunc     = 8'd0;
                        n_rbc       = 8'd0;
                        n_pend      = 8'd0;
                    end
                end
                mbfc4_pkg::KIND_BYTE: begin
                    if (r_receiving) begin
                        if (r_bytes >= 8'd2) begin
                            n_crc = mbfc4_pkg::crc_feed(r_crc, r_lag[15:8]);
                        end
                        n_lag = {r_lag[7:0], i_rx_byte};
                        if (r_bytes == 8'd0) begin
                            n_raddr = i_rx_byte;
                        end else if (r_bytes == 8'd1) begin
                            n_rfunc = i_rx_byte;
                        end else if (r_bytes == 8'd2) begin
                            n_rbc = i_rx_byte;
                        end else if ({1'b0, r_bytes} < data_end) begin
                            // odd position holds the high byte, even completes a word
                            if (r_bytes[0]) begin
                                n_pend = i_rx_byte;
                            end else begin
                                o_burst.word_go = 1'b1;
                                o_burst.word    = {r_pend, i_rx_byte};
                                o_burst.widx    = pm4[7:1];
                            end
                        end
                        n_bytes = r_bytes + 8'd1;
                        fin = ({1'b0, n_bytes} >= (data_end + 9'd2));
                    end
                end
                mbfc4_pkg::KIND_TICK: begin
                    if (r_receiving) begin
                        if (r_elapsed != 16'hFFFF) begin
                            n_elapsed = r_elapsed + 16'd1;
                        end
                        fin = (n_elapsed >= r_timeout);
                    end
                end
                default: ;
            endcase
        end

        got = {n_lag[7:0], n_lag[15:8]};
        if (fin) begin
            if (n_bytes < mbfc4_pkg::MIN_REPLY) begin
                st = mbfc4_pkg::ST_TIMEOUT;
            end else if (n_raddr != r_slave) begin
                st = mbfc4_pkg::ST_ADDRESS;
            end else if (n_rfunc == mbfc4_pkg::FUNC_EXCEPT) begin
                st  = mbfc4_pkg::ST_EXCEPTION;
                exc = n_rbc;
            end else if (n_rfunc != mbfc4_pkg::FUNC_CODE) begin
                st = mbfc4_pkg::ST_FUNCTION;
            end else if ((n_rbc != {r_exp, 1'b0}) ||
                         ({1'b0, n_bytes} < ({1'b0, n_rbc} + 9'd5))) begin
                st = mbfc4_pkg::ST_SIZE;
            end else if (got != n_crc) begin
                st = mbfc4_pkg::ST_CRC;
            end
            if (st != mbfc4_pkg::ST_OK) begin
                n_fail = r_fail + 32'd1;
            end
            n_receiving     = 1'b0;
            o_burst.stat_go = 1'b1;
            o_burst.status  = st;
            o_burst.exc     = exc;
            o_burst.total   = n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave     <= mbfc4_pkg::RST_SLAVE_ADDRESS;
            r_timeout   <= mbfc4_pkg::RST_TIMEOUT_TICKS;
            r_max       <= mbfc4_pkg::RST_MAX_COUNT;
            r_receiving <= 1'b0;
            r_exp       <= 7'd0;
            r_bytes     <= 8'd0;
            r_elapsed   <= 16'd0;
            r_crc       <= mbfc4_pkg::CRC_INIT;
            r_lag       <= 16'd0;
            r_raddr     <= 8'd0;
            r_rfunc     <= 8'd0;
            r_rbc       <= 8'd0;
            r_pend      <= 8'd0;
            r_fail      <= 32'd0;
        end else begin
            r_slave     <= n_slave;
            r_timeout   <= n_timeout;
            r_max       <= n_max;
            r_receiving <= n_receiving;
            r_exp       <= n_exp;
            r_bytes     <= n_bytes;
            r_elapsed   <= n_elapsed;
            r_crc       <= n_crc;
            r_lag       <= n_lag;
            r_raddr     <= n_raddr;
            r_rfunc     <= n_rfunc;
            r_rbc       <= n_rbc;
            r_pend      <= n_pend;
            r_fail      <= n_fail;
        end
    end

endmodule

// File: src/mbfc4_emit.sv
// ----------------------------------------------------------------------------
// mbfc4_emit
// Result register: holds one burst and hands its items out one per transaction.
// ----------------------------------------------------------------------------
module mbfc4_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  mbfc4_pkg::t_burst     i_burst,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_out_kind,
    output logic [7:0]            o_tx_byte,
    output logic [15:0]           o_register_word,
    output logic [6:0]            o_word_index,
    output logic [2:0]            o_status,
    output logic [7:0]            o_exception_code,
    output logic [31:0]           o_error_total,
    output logic                  o_last
);

    logic [3:0]  r_left,      n_left;
    logic [2:0]  r_pos,       n_pos;
    logic [15:0] r_crc,       n_crc;
    logic        r_word_pend, n_word_pend;
    logic        r_stat_pend, n_stat_pend;
    mbfc4_pkg::t_burst r_pl;

    logic       pop;
    logic       one_left;
    logic [7:0] tx_sel;

    always_comb begin
        unique case (r_pos)
            3'd0: tx_sel = r_pl.slave;
            3'd1: tx_sel = mbfc4_pkg::FUNC_CODE;
            3'd2: tx_sel = r_pl.addr[15:8];
            3'd3: tx_sel = r_pl.addr[7:0];
            3'd4: tx_sel = r_pl.cnt[15:8];
            3'd5: tx_sel = r_pl.cnt[7:0];
            3'd6: tx_sel = r_crc[7:0];
            3'd7: tx_sel = r_crc[15:8];
        endcase
    end

    assign o_out_valid = (r_left != 4'd0) || r_word_pend || r_stat_pend;
    assign pop         = o_out_valid && !i_out_stall;
    assign one_left    = ((r_left == 4'd1) && !r_word_pend && !r_stat_pend) ||
                         ((r_left == 4'd0) && (r_word_pend ^ r_stat_pend));
    assign o_free      = !o_out_valid || (pop && one_left);

    // request bytes first, then the word, then the status
    always_comb begin
        o_out_kind       = mbfc4_pkg::OUT_STATUS;
        o_tx_byte        = 8'h00;
        o_register_word  = 16'h0000;
        o_word_index     = 7'd0;
        o_status         = mbfc4_pkg::ST_OK;
        o_exception_code = 8'h00;
        o_error_total    = 32'd0;
        o_last           = 1'b0;
        if (r_left != 4'd0) begin
            o_out_kind = mbfc4_pkg::OUT_REQ;
            o_tx_byte  = tx_sel;
            o_last     = (r_pos == 3'd7);
        end else if (r_word_pend) begin
            o_out_kind      = mbfc4_pkg::OUT_WORD;
            o_register_word = r_pl.word;
            o_word_index    = r_pl.widx;
        end else begin
            o_status         = r_pl.status;
            o_exception_code = r_pl.exc;
            o_error_total    = r_pl.total;
            o_last           = 1'b1;
        end
    end

    always_comb begin
        n_left      = r_left;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_word_pend = r_word_pend;
        n_stat_pend = r_stat_pend;
        if (pop) begin
            if (r_left != 4'd0) begin
                n_left = r_left - 4'd1;
                n_pos  = r_pos + 3'd1;
                // fold header bytes into the CRC as they leave
                if (r_pos < 3'd6) begin
                    n_crc = mbfc4_pkg::crc_feed(r_crc, tx_sel);
                end
            end else if (r_word_pend) begin
                n_word_pend = 1'b0;
            end else begin
                n_stat_pend = 1'b0;
            end
        end
        if (i_load) begin
            n_left      = i_burst.req_go ? mbfc4_pkg::REQ_LEN : 4'd0;
            n_pos       = 3'd0;
            n_crc       = mbfc4_pkg::CRC_INIT;
            n_word_pend = i_burst.word_go;
            n_stat_pend = i_burst.stat_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 4'd0;
            r_pos       <= 3'd0;
            r_crc       <= mbfc4_pkg::CRC_INIT;
            r_word_pend <= 1'b0;
            r_stat_pend <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_word_pend <= n_word_pend;
            r_stat_pend <= n_stat_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pl <= i_burst;
        end
    end

endmodule

// File: src/modbus_fc04_master_checker.sv
// ----------------------------------------------------------------------------
// modbus_fc04_master_checker
// Modbus RTU master for function 04 (read input registers), streaming form.
// ----------------------------------------------------------------------------
// A transaction on the input channel is a start request, a received bus byte
// or a one millisecond tick. A start request with a nonzero, even register
// count no larger than max_count (capped at 124) produces the eight request
// bytes with CRC-16 low byte first; any other count produces a rejected
// status. Reply bytes are checked in order address, exception, function,
// byte count and CRC; register words come out as soon as their low byte
// arrives and stay provisional until the closing status, which carries the
// running error total. Each input transaction passes one input register and
// is evaluated once output is free, so bytes and ticks are taken at one
// per cycle while the output side keeps up. A start holds the output register
// for eight transactions (the request CRC is built byte by byte as the bytes
// leave); every other input transaction causes at most one result, since a
// reply closes two bytes after its last register word. The next input
// transaction is evaluated on the cycle the last result of the previous one
// is taken. Configuration writes are taken every cycle and are meant for idle
// periods only. No memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
module modbus_fc04_master_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_start_address,
    input  logic [15:0] i_register_count,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_register_word,
    output logic [6:0]  o_word_index,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic [31:0] o_error_total,
    output logic        o_last
);

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_start_address;
    logic [15:0] r_register_count;
    logic [7:0]  r_rx_byte;

    logic              emit_free;
    logic              core_go;
    logic              in_take;
    mbfc4_pkg::t_burst burst;

    // Evaluate the held transaction once the output register will be empty.
    assign core_go     = r_in_valid && emit_free;
    assign o_in_stall  = r_in_valid && !core_go;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (core_go) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload holds while stalled; load only on a taken transaction.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind           <= i_kind;
            r_start_address  <= i_start_address;
            r_register_count <= i_register_count;
            r_rx_byte        <= i_rx_byte;
        end
    end

    mbfc4_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_go             (core_go),
        .i_kind           (r_kind),
        .i_start_address  (r_start_address),
        .i_register_count (r_register_count),
        .i_rx_byte        (r_rx_byte),
        .o_burst          (burst)
    );

    mbfc4_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (core_go),
        .i_burst          (burst),
        .o_free           (emit_free),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_kind       (o_out_kind),
        .o_tx_byte        (o_tx_byte),
        .o_register_word  (o_register_word),
        .o_word_index     (o_word_index),
        .o_status         (o_status),
        .o_exception_code (o_exception_code),
        .o_error_total    (o_error_total),
        .o_last           (o_last)
    );

endmodule

// File: src/mbfc4_checker.sv
// ----------------------------------------------------------------------------
// mbfc4_checker
// Port-level properties of the function 04 master, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_fc04_master_checker_assert.svh"

module mbfc4_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_out_kind,
    input logic [7:0]  o_tx_byte,
    input logic [15:0] o_register_word,
    input logic [2:0]  o_status,
    input logic [31:0] o_error_total,
    input logic        o_last
);

    // A stalled result holds.
    `MBFC4_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_kind) && $stable(o_tx_byte) && $stable(o_register_word) && $stable(o_status) && $stable(o_error_total) && $stable(o_last))

    // Every status closes its burst.
    `MBFC4_ASSERT_SAME(a_status_last, i_clk, i_rst_n, o_out_valid && (o_out_kind == mbfc4_pkg::OUT_STATUS), o_last)

    // Only statuses carry the error total and only request bytes a tx byte.
    `MBFC4_ASSERT_SAME(a_fields_zero, i_clk, i_rst_n, o_out_valid && (o_out_kind != mbfc4_pkg::OUT_STATUS), (o_error_total == 32'd0) && ((o_out_kind == mbfc4_pkg::OUT_REQ) || (o_tx_byte == 8'h00)))

    // With nothing waiting on the output side the input never stalls.
    `MBFC4_ASSERT_SAME(a_no_idle_stall, i_clk, i_rst_n, !o_out_valid, !o_in_stall)

endmodule

bind modbus_fc04_master_checker mbfc4_checker u_mbfc4_checker (.*);
